[design/owbm_pkg.sv]
package owbm_pkg;

   localparam int unsigned TICK_W       = 10;
   localparam int unsigned BYTE_W       = 8;
   localparam int unsigned ACTION_W     = 2;
   localparam int unsigned BIT_IDX_W    = 4;
   localparam int unsigned REQ_DATA_W   = 16;
   localparam int unsigned RSP_DATA_W   = 16;
   localparam int unsigned CSR_ADDR_W   = 5;
   localparam int unsigned CSR_DATA_W   = 32;

   localparam int unsigned RECOVERY_TICKS_DEFAULT = 2;
   localparam int unsigned QUEUE_DEPTH_DEFAULT    = 4;

   localparam logic [ACTION_W-1:0] ACT_NONE  = 2'd0;
   localparam logic [ACTION_W-1:0] ACT_RESET = 2'd1;
   localparam logic [ACTION_W-1:0] ACT_WRITE = 2'd2;
   localparam logic [ACTION_W-1:0] ACT_READ  = 2'd3;

   localparam logic [2:0] REG_RESET_LOW       = 3'd0;
   localparam logic [2:0] REG_PRESENCE_SAMPLE = 3'd1;
   localparam logic [2:0] REG_RESET_TAIL      = 3'd2;
   localparam logic [2:0] REG_WRITE_LOW       = 3'd3;
   localparam logic [2:0] REG_WRITE_HOLD      = 3'd4;
   localparam logic [2:0] REG_READ_LOW        = 3'd5;
   localparam logic [2:0] REG_READ_SAMPLE     = 3'd6;
   localparam logic [2:0] REG_READ_TAIL       = 3'd7;

   localparam logic [TICK_W-1:0] RESET_LOW_INIT       = 10'd900;
   localparam logic [TICK_W-1:0] PRESENCE_SAMPLE_INIT = 10'd70;
   localparam logic [TICK_W-1:0] RESET_TAIL_INIT      = 10'd200;
   localparam logic [TICK_W-1:0] WRITE_LOW_INIT       = 10'd20;
   localparam logic [TICK_W-1:0] WRITE_HOLD_INIT      = 10'd30;
   localparam logic [TICK_W-1:0] READ_LOW_INIT        = 10'd2;
   localparam logic [TICK_W-1:0] READ_SAMPLE_INIT     = 10'd25;
   localparam logic [TICK_W-1:0] READ_TAIL_INIT       = 10'd70;

   typedef struct packed {
      logic [TICK_W-1:0] reset_low;
      logic [TICK_W-1:0] presence_sample;
      logic [TICK_W-1:0] reset_tail;
      logic [TICK_W-1:0] write_low;
      logic [TICK_W-1:0] write_hold;
      logic [TICK_W-1:0] read_low;
      logic [TICK_W-1:0] read_sample;
      logic [TICK_W-1:0] read_tail;
   } timing_type;

   typedef struct packed {
      logic              start_reset;
      logic              start_write;
      logic              start_read;
      logic [BYTE_W-1:0] tx_byte;
      logic              line_level;
   } item_type;

   typedef struct packed {
      logic              drive_low;
      logic              busy_res;
      logic              done_res;
      logic [BYTE_W-1:0] rx_byte;
      logic              device_present;
   } result_type;

endpackage

[design/one_wire_bus_master_unit.sv]
// Channel   Dir  Ports                                  Word
// req       in   req_tvalid/req_tready/req_tdata/tuser  one bus tick: command, tx byte, line
// rsp       out  rsp_tvalid/rsp_tready/rsp_tdata        bus drive and status for that tick
// csr       in   csr_psel/penable/pwrite/paddr/pwdata    eight 10-bit timing registers
//
// One word per clock sustained while rsp_tready is high; each word is one sequencer step.
// req words pass through the queue (QUEUE_DEPTH words) into the registered rsp output.
// Synchronous active-high reset; timing registers load their default values.
// req stalls only when the queue is full; rsp stalls hold the output register and back
// the queue up while req keeps being taken.
module one_wire_bus_master_unit #(
   parameter int unsigned RECOVERY_TICKS = owbm_pkg::RECOVERY_TICKS_DEFAULT,
   parameter int unsigned QUEUE_DEPTH    = owbm_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic                               clock,
   input  logic                               reset,
   // tdata: tx_byte[7:0], line_level[8], zero [15:9]
   input  logic [owbm_pkg::REQ_DATA_W-1:0]    req_tdata,
   // tuser: action[1:0]
   input  logic [owbm_pkg::ACTION_W-1:0]      req_tuser,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   // tdata: drive_low[0], busy_res[1], done_res[2], rx_byte[10:3], device_present[11],
   //        zero [15:12]
   output logic [owbm_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   input  logic                               csr_psel,
   input  logic                               csr_penable,
   input  logic                               csr_pwrite,
   input  logic [owbm_pkg::CSR_ADDR_W-1:0]    csr_paddr,
   input  logic [owbm_pkg::CSR_DATA_W-1:0]    csr_pwdata,
   output logic [owbm_pkg::CSR_DATA_W-1:0]    csr_prdata,
   output logic                               csr_pready
);

   owbm_pkg::timing_type timing;
   owbm_pkg::item_type   push_item;
   owbm_pkg::item_type   head_item;
   logic                 push;
   logic                 pop;
   logic                 queue_full;
   logic                 queue_not_empty;

   owbm_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .timing      (timing)
   );

   owbm_front u_front (
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .queue_full (queue_full),
      .push       (push),
      .push_item  (push_item)
   );

   owbm_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (push_item),
      .full      (queue_full),
      .pop       (pop),
      .not_empty (queue_not_empty),
      .head_item (head_item)
   );

   owbm_seq #(
      .RECOVERY_TICKS (RECOVERY_TICKS)
   ) u_seq (
      .clock      (clock),
      .reset      (reset),
      .timing     (timing),
      .item_valid (queue_not_empty),
      .item       (head_item),
      .pop        (pop),
      .rsp_tdata  (rsp_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready)
   );

endmodule

[design/owbm_csr.sv]
module owbm_csr (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_psel,
   input  logic                               csr_penable,
   input  logic                               csr_pwrite,
   input  logic [owbm_pkg::CSR_ADDR_W-1:0]    csr_paddr,
   input  logic [owbm_pkg::CSR_DATA_W-1:0]    csr_pwdata,
   output logic [owbm_pkg::CSR_DATA_W-1:0]    csr_prdata,
   output logic                               csr_pready,
   output owbm_pkg::timing_type               timing
);

   owbm_pkg::timing_type            timing_ff;
   owbm_pkg::timing_type            timing_in;
   logic [2:0]                      reg_idx;
   logic [owbm_pkg::TICK_W-1:0]     wr_val;
   logic [owbm_pkg::TICK_W-1:0]     rd_val;
   logic                            wr_en;

   assign reg_idx    = csr_paddr[owbm_pkg::CSR_ADDR_W-1:2];
   assign wr_val     = csr_pwdata[owbm_pkg::TICK_W-1:0];
   assign wr_en      = csr_psel & csr_penable & csr_pwrite;
   assign csr_pready = 1'b1;
   assign timing     = timing_ff;

   always_comb begin
      timing_in = timing_ff;
      if (wr_en) begin
         case (reg_idx)
            owbm_pkg::REG_RESET_LOW:       timing_in.reset_low       = wr_val;
            owbm_pkg::REG_PRESENCE_SAMPLE: timing_in.presence_sample = wr_val;
            owbm_pkg::REG_RESET_TAIL:      timing_in.reset_tail      = wr_val;
            owbm_pkg::REG_WRITE_LOW:       timing_in.write_low       = wr_val;
            owbm_pkg::REG_WRITE_HOLD:      timing_in.write_hold      = wr_val;
            owbm_pkg::REG_READ_LOW:        timing_in.read_low        = wr_val;
            owbm_pkg::REG_READ_SAMPLE:     timing_in.read_sample     = wr_val;
            owbm_pkg::REG_READ_TAIL:       timing_in.read_tail       = wr_val;
            default:                       timing_in = timing_ff;
         endcase
      end
   end

   always_comb begin
      case (reg_idx)
         owbm_pkg::REG_RESET_LOW:       rd_val = timing_ff.reset_low;
         owbm_pkg::REG_PRESENCE_SAMPLE: rd_val = timing_ff.presence_sample;
         owbm_pkg::REG_RESET_TAIL:      rd_val = timing_ff.reset_tail;
         owbm_pkg::REG_WRITE_LOW:       rd_val = timing_ff.write_low;
         owbm_pkg::REG_WRITE_HOLD:      rd_val = timing_ff.write_hold;
         owbm_pkg::REG_READ_LOW:        rd_val = timing_ff.read_low;
         owbm_pkg::REG_READ_SAMPLE:     rd_val = timing_ff.read_sample;
         owbm_pkg::REG_READ_TAIL:       rd_val = timing_ff.read_tail;
         default:                       rd_val = '0;
      endcase
   end

   assign csr_prdata = {{(owbm_pkg::CSR_DATA_W-owbm_pkg::TICK_W){1'b0}}, rd_val};

   always_ff @(posedge clock) begin
      if (reset) begin
         timing_ff.reset_low       <= owbm_pkg::RESET_LOW_INIT;
         timing_ff.presence_sample <= owbm_pkg::PRESENCE_SAMPLE_INIT;
         timing_ff.reset_tail      <= owbm_pkg::RESET_TAIL_INIT;
         timing_ff.write_low       <= owbm_pkg::WRITE_LOW_INIT;
         timing_ff.write_hold      <= owbm_pkg::WRITE_HOLD_INIT;
         timing_ff.read_low        <= owbm_pkg::READ_LOW_INIT;
         timing_ff.read_sample     <= owbm_pkg::READ_SAMPLE_INIT;
         timing_ff.read_tail       <= owbm_pkg::READ_TAIL_INIT;
      end else begin
         timing_ff <= timing_in;
      end
   end

endmodule

[design/owbm_front.sv]
module owbm_front (
   input  logic [owbm_pkg::REQ_DATA_W-1:0]  req_tdata,
   input  logic [owbm_pkg::ACTION_W-1:0]    req_tuser,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic                             queue_full,
   output logic                             push,
   output owbm_pkg::item_type               push_item
);

   assign req_tready = ~queue_full;
   assign push       = req_tvalid & ~queue_full;

   always_comb begin
      push_item             = '0;
      push_item.tx_byte     = req_tdata[owbm_pkg::BYTE_W-1:0];
      push_item.line_level  = req_tdata[owbm_pkg::BYTE_W];
      case (req_tuser)
         owbm_pkg::ACT_RESET: push_item.start_reset = 1'b1;
         owbm_pkg::ACT_WRITE: push_item.start_write = 1'b1;
         owbm_pkg::ACT_READ:  push_item.start_read  = 1'b1;
         default:             push_item.start_reset = 1'b0;
      endcase
   end

endmodule

[design/owbm_queue.sv]
module owbm_queue #(
   parameter int unsigned DEPTH = owbm_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  owbm_pkg::item_type   push_item,
   output logic                 full,
   input  logic                 pop,
   output logic                 not_empty,
   output owbm_pkg::item_type   head_item
);

   localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);

   owbm_pkg::item_type   slot_ff [DEPTH];
   logic [PTR_W-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]     count_ff, count_in;

   assign full      = (count_ff == CNT_W'(DEPTH));
   assign not_empty = (count_ff != '0);
   assign head_item = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

[design/owbm_seq.sv]
module owbm_seq #(
   parameter int unsigned RECOVERY_TICKS = owbm_pkg::RECOVERY_TICKS_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   input  owbm_pkg::timing_type              timing,
   input  logic                              item_valid,
   input  owbm_pkg::item_type                item,
   output logic                              pop,
   output logic [owbm_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready
);

   localparam logic [3:0] PH_IDLE     = 4'd0;
   localparam logic [3:0] PH_RST_LOW  = 4'd1;
   localparam logic [3:0] PH_RST_WAIT = 4'd2;
   localparam logic [3:0] PH_RST_TAIL = 4'd3;
   localparam logic [3:0] PH_WR_LOW   = 4'd4;
   localparam logic [3:0] PH_WR_HOLD  = 4'd5;
   localparam logic [3:0] PH_WR_REC   = 4'd6;
   localparam logic [3:0] PH_RD_LOW   = 4'd7;
   localparam logic [3:0] PH_RD_WAIT  = 4'd8;
   localparam logic [3:0] PH_RD_TAIL  = 4'd9;
   localparam logic [3:0] PH_RD_REC   = 4'd10;

   localparam int unsigned TW = owbm_pkg::TICK_W;
   localparam int unsigned BW = owbm_pkg::BYTE_W;
   localparam int unsigned IW = owbm_pkg::BIT_IDX_W;

   logic [3:0]     phase_ff, phase_in;
   logic [TW-1:0]  tick_ff, tick_in;
   logic [BW-1:0]  shift_ff, shift_in;
   logic [IW-1:0]  bit_idx_ff, bit_idx_in;
   logic           presence_ff, presence_in;
   logic [BW-1:0]  rx_last_ff, rx_last_in;
   logic           rsp_valid_ff, rsp_valid_in;
   owbm_pkg::result_type res_ff, res_in;

   logic [3:0]     ph0;
   logic [TW-1:0]  cnt0;
   logic [BW-1:0]  sh0;
   logic [IW-1:0]  bi0;
   logic [IW-1:0]  bi_next;
   logic [TW-1:0]  len;
   logic [TW:0]    cnt_inc;

   assign pop = item_valid & (~rsp_valid_ff | rsp_tready);

   always_comb begin
      ph0  = phase_ff;
      cnt0 = tick_ff;
      sh0  = shift_ff;
      bi0  = bit_idx_ff;
      if (phase_ff == PH_IDLE || phase_ff > PH_RD_REC) begin
         ph0  = PH_IDLE;
         cnt0 = '0;
         if (item.start_reset) begin
            ph0 = PH_RST_LOW;
         end else if (item.start_write) begin
            ph0 = PH_WR_LOW;
            sh0 = item.tx_byte;
            bi0 = '0;
         end else if (item.start_read) begin
            ph0 = PH_RD_LOW;
            sh0 = '0;
            bi0 = '0;
         end
      end
   end

   always_comb begin
      case (ph0)
         PH_RST_LOW:  len = timing.reset_low;
         PH_RST_WAIT: len = timing.presence_sample;
         PH_RST_TAIL: len = timing.reset_tail;
         PH_WR_LOW:   len = timing.write_low;
         PH_WR_HOLD:  len = timing.write_hold;
         PH_RD_LOW:   len = timing.read_low;
         PH_RD_WAIT:  len = timing.read_sample;
         PH_RD_TAIL:  len = timing.read_tail;
         default:     len = TW'(RECOVERY_TICKS);
      endcase
   end

   assign cnt_inc = {1'b0, cnt0} + 1'b1;
   assign bi_next = bi0 + 1'b1;

   always_comb begin
      phase_in    = ph0;
      tick_in     = cnt0;
      shift_in    = sh0;
      bit_idx_in  = bi0;
      presence_in = presence_ff;
      rx_last_in  = rx_last_ff;
      res_in      = '0;
      if (ph0 != PH_IDLE) begin
         res_in.busy_res = 1'b1;
         if (ph0 == PH_RST_LOW || ph0 == PH_WR_LOW || ph0 == PH_RD_LOW) begin
            res_in.drive_low = 1'b1;
         end else if (ph0 == PH_WR_HOLD) begin
            res_in.drive_low = ~sh0[0];
         end
         if (cnt_inc < {1'b0, len}) begin
            tick_in = cnt_inc[TW-1:0];
         end else begin
            tick_in = '0;
            case (ph0)
               PH_RST_LOW:  phase_in = PH_RST_WAIT;
               PH_RST_WAIT: begin
                  presence_in = ~item.line_level;
                  phase_in    = PH_RST_TAIL;
               end
               PH_RST_TAIL: begin
                  phase_in        = PH_IDLE;
                  res_in.done_res = 1'b1;
               end
               PH_WR_LOW:   phase_in = PH_WR_HOLD;
               PH_WR_HOLD:  phase_in = PH_WR_REC;
               PH_WR_REC: begin
                  shift_in = {1'b0, sh0[BW-1:1]};
                  if (bi_next >= IW'(BW)) begin
                     bit_idx_in      = '0;
                     phase_in        = PH_IDLE;
                     res_in.done_res = 1'b1;
                  end else begin
                     bit_idx_in = bi_next;
                     phase_in   = PH_WR_LOW;
                  end
               end
               PH_RD_LOW:   phase_in = PH_RD_WAIT;
               PH_RD_WAIT: begin
                  shift_in = {item.line_level, sh0[BW-1:1]};
                  phase_in = PH_RD_TAIL;
               end
               PH_RD_TAIL:  phase_in = PH_RD_REC;
               default: begin
                  if (bi_next >= IW'(BW)) begin
                     bit_idx_in      = '0;
                     rx_last_in      = sh0;
                     phase_in        = PH_IDLE;
                     res_in.done_res = 1'b1;
                  end else begin
                     bit_idx_in = bi_next;
                     phase_in   = PH_RD_LOW;
                  end
               end
            endcase
         end
      end
      res_in.rx_byte        = rx_last_in;
      res_in.device_present = presence_in;
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (pop) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_IDLE;
         tick_ff      <= '0;
         shift_ff     <= '0;
         bit_idx_ff   <= '0;
         presence_ff  <= 1'b0;
         rx_last_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (pop) begin
            phase_ff    <= phase_in;
            tick_ff     <= tick_in;
            shift_ff    <= shift_in;
            bit_idx_ff  <= bit_idx_in;
            presence_ff <= presence_in;
            rx_last_ff  <= rx_last_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         res_ff <= res_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(owbm_pkg::RSP_DATA_W-12){1'b0}}, res_ff.device_present,
                        res_ff.rx_byte, res_ff.done_res, res_ff.busy_res,
                        res_ff.drive_low};

endmodule
